### design/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and codes for the round-robin slice scheduler.
// ----------------------------------------------------------------------------
package rrss_pkg;

  // default number of process slots, root included
  localparam int unsigned MaxProcessesDef = 16;

  // configuration port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // register indexes, taken from paddr[2]
  localparam logic RegTimeSlice = 1'b0;
  localparam logic RegKernelPid = 1'b1;

  // register reset values
  localparam logic [15:0] TimeSliceRst = 16'd10;
  localparam logic [15:0] KernelPidRst = 16'd0;

  // operation codes
  localparam logic [2:0] OpTick   = 3'd0;
  localparam logic [2:0] OpAdd    = 3'd1;
  localparam logic [2:0] OpRemove = 3'd2;
  localparam logic [2:0] OpYield  = 3'd3;
  localparam logic [2:0] OpKill   = 3'd4;
  localparam logic [2:0] OpFind   = 3'd5;

  // result status codes
  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;
  localparam logic [1:0] StatCurrent  = 2'd3;

  // configuration seen by the sequencer
  typedef struct packed {
    logic [15:0] time_slice;
    logic [15:0] kernel_pid;
  } cfg_t;

endpackage

### design/rrss_ram.sv
// ----------------------------------------------------------------------------
// rrss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rrss_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/rrss_regs.sv
// ----------------------------------------------------------------------------
// rrss_regs
// APB-style register file holding the time slice and the root pid.
// ----------------------------------------------------------------------------
module rrss_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrss_pkg::AddrW-1:0]  paddr,
  input  logic [rrss_pkg::DataW-1:0]  pwdata,
  output logic [rrss_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output rrss_pkg::cfg_t              cfg_o
);

  logic [15:0] time_slice_q;
  logic [15:0] kernel_pid_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_slice_q <= rrss_pkg::TimeSliceRst;
      kernel_pid_q <= rrss_pkg::KernelPidRst;
    end else if (wr_en) begin
      if (paddr[2] == rrss_pkg::RegTimeSlice) begin
        time_slice_q <= pwdata[15:0];
      end else begin
        kernel_pid_q <= pwdata[15:0];
      end
    end
  end

  // read mux
  always_comb begin
    case (paddr[2])
      rrss_pkg::RegTimeSlice: prdata = {16'd0, time_slice_q};
      rrss_pkg::RegKernelPid: prdata = {16'd0, kernel_pid_q};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.time_slice = time_slice_q;
  assign cfg_o.kernel_pid = kernel_pid_q;

endmodule

### design/round_robin_slice_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Round-robin time-slice scheduler over a linked ring of process slots.
// ----------------------------------------------------------------------------
// One operation is handled at a time and in_stall_o stays high until its
// result beat has been taken. Slot pids, links and run times live in RAMs
// with one read port each, so every slot visited takes a read state and a
// compare state. Each operation passes ST_CUR and ST_DISPATCH: a tick that
// only charges the slot then goes to ST_OUT, a switch reads the new pid in
// ST_NEW_RD and ST_NEW_PID, an add scans the slot flags one slot per cycle
// and links the slot in ST_ADD_LINK, and remove or find follow the ring link
// by link. The result waits in ST_OUT on out_stall_i, and ST_IDLE comes
// again before the next beat is taken. No clearing pass runs after reset.
module round_robin_slice_scheduler #(
  parameter int unsigned MAX_PROCESSES = rrss_pkg::MaxProcessesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rrss_pkg::AddrW-1:0] paddr,
  input  logic [rrss_pkg::DataW-1:0] pwdata,
  output logic [rrss_pkg::DataW-1:0] prdata,
  output logic                       pready,
  // operation beats
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 op_i,
  input  logic [15:0]                pid_i,
  // result beats
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic                       switched_o,
  output logic [15:0]                old_pid_o,
  output logic [15:0]                new_pid_o,
  output logic [4:0]                 process_count_o,
  output logic [31:0]                run_time_o
);

  localparam int unsigned SW = $clog2(MAX_PROCESSES);
  localparam int unsigned CW = $clog2(MAX_PROCESSES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CUR, ST_DISPATCH, ST_ADD_SCAN, ST_ADD_LINK,
    ST_WALK_RD, ST_WALK_CMP, ST_NEW_RD, ST_NEW_PID, ST_OUT
  } state_e;

  rrss_pkg::cfg_t cfg;

  state_e state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic [15:0]         pid_q, pid_d;
  logic [SW-1:0]       cur_q, cur_d;
  logic [SW-1:0]       tail_q, tail_d;
  logic [SW-1:0]       next0_q, next0_d;
  logic [SW-1:0]       ptr_q, ptr_d;
  logic [SW-1:0]       prev_q, prev_d;
  logic [15:0]         ticks_q, ticks_d;
  logic [CW-1:0]       count_q, count_d;
  logic [31:0]         rt0_q, rt0_d;
  logic [MAX_PROCESSES-1:0] valid_q, valid_d;
  logic [MAX_PROCESSES-1:0] doomed_q, doomed_d;

  logic [1:0]  status_q, status_d;
  logic        switched_q, switched_d;
  logic [15:0] old_pid_q, old_pid_d;
  logic [15:0] new_pid_q, new_pid_d;
  logic [31:0] rt_out_q, rt_out_d;

  // ram ports
  logic          pid_we, rt_we, next_we;
  logic [SW-1:0] pid_waddr, rt_waddr, next_waddr;
  logic [15:0]   pid_wdata;
  logic [31:0]   rt_wdata;
  logic [SW-1:0] next_wdata;
  logic [15:0]   pid_rd;
  logic [31:0]   rt_rd;
  logic [SW-1:0] next_rd;

  // helpers
  logic [15:0]   sel_pid;
  logic [SW-1:0] cur_next;
  logic [31:0]   cur_rt;
  logic [31:0]   rt_inc;
  logic          nx_doomed;

  rrss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rrss_ram #(.Width(16), .Depth(MAX_PROCESSES)) u_pid_ram (
    .clk_i   (clk_i),
    .we_i    (pid_we),
    .waddr_i (pid_waddr),
    .wdata_i (pid_wdata),
    .raddr_i (ptr_q),
    .rdata_o (pid_rd)
  );

  rrss_ram #(.Width(32), .Depth(MAX_PROCESSES)) u_rt_ram (
    .clk_i   (clk_i),
    .we_i    (rt_we),
    .waddr_i (rt_waddr),
    .wdata_i (rt_wdata),
    .raddr_i (ptr_q),
    .rdata_o (rt_rd)
  );

  rrss_ram #(.Width(SW), .Depth(MAX_PROCESSES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (ptr_q),
    .rdata_o (next_rd)
  );

  // slot zero fields come from registers, the rest from the rams
  assign sel_pid   = (ptr_q == '0) ? cfg.kernel_pid : pid_rd;
  assign cur_next  = (cur_q == '0) ? next0_q : next_rd;
  assign cur_rt    = (cur_q == '0) ? rt0_q : rt_rd;
  assign rt_inc    = (cur_rt == 32'hFFFF_FFFF) ? cur_rt : cur_rt + 32'd1;
  assign nx_doomed = doomed_q[cur_next] | ((op_q == rrss_pkg::OpKill) && (cur_next == cur_q));

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    pid_d      = pid_q;
    cur_d      = cur_q;
    tail_d     = tail_q;
    next0_d    = next0_q;
    ptr_d      = ptr_q;
    prev_d     = prev_q;
    ticks_d    = ticks_q;
    count_d    = count_q;
    rt0_d      = rt0_q;
    valid_d    = valid_q;
    doomed_d   = doomed_q;
    status_d   = status_q;
    switched_d = switched_q;
    old_pid_d  = old_pid_q;
    new_pid_d  = new_pid_q;
    rt_out_d   = rt_out_q;
    pid_we     = 1'b0;
    pid_waddr  = ptr_q;
    pid_wdata  = pid_q;
    rt_we      = 1'b0;
    rt_waddr   = ptr_q;
    rt_wdata   = '0;
    next_we    = 1'b0;
    next_waddr = ptr_q;
    next_wdata = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          pid_d   = pid_i;
          ptr_d   = cur_q;
          state_d = ST_CUR;
        end
      end

      // read the current slot
      ST_CUR: state_d = ST_DISPATCH;

      ST_DISPATCH: begin
        old_pid_d  = sel_pid;
        new_pid_d  = sel_pid;
        status_d   = rrss_pkg::StatOk;
        switched_d = 1'b0;
        rt_out_d   = '0;
        state_d    = ST_OUT;
        case (op_q)
          rrss_pkg::OpTick, rrss_pkg::OpYield, rrss_pkg::OpKill: begin
            if (op_q == rrss_pkg::OpTick && ticks_q != '0) begin
              // charge one tick to the current slot
              if (cur_q == '0) begin
                rt0_d = rt_inc;
              end else begin
                rt_we    = 1'b1;
                rt_waddr = cur_q;
                rt_wdata = rt_inc;
              end
              ticks_d = ticks_q - 16'd1;
            end else begin
              // switch to the next slot, or the root when it is doomed
              if (op_q == rrss_pkg::OpKill) begin
                doomed_d[cur_q] = 1'b1;
              end
              cur_d      = nx_doomed ? '0 : cur_next;
              ptr_d      = nx_doomed ? '0 : cur_next;
              ticks_d    = cfg.time_slice;
              switched_d = 1'b1;
              state_d    = ST_NEW_RD;
            end
          end
          rrss_pkg::OpAdd: begin
            ptr_d   = SW'(1);
            state_d = ST_ADD_SCAN;
          end
          rrss_pkg::OpRemove: begin
            status_d = rrss_pkg::StatNotFound;
            prev_d   = '0;
            ptr_d    = next0_q;
            state_d  = (next0_q == '0) ? ST_OUT : ST_WALK_RD;
          end
          rrss_pkg::OpFind: begin
            if (cfg.kernel_pid == pid_q) begin
              rt_out_d = rt0_q;
            end else begin
              status_d = rrss_pkg::StatNotFound;
              ptr_d    = next0_q;
              state_d  = (next0_q == '0) ? ST_OUT : ST_WALK_RD;
            end
          end
          default: state_d = ST_OUT;
        endcase
      end

      // lowest free slot, one per cycle
      ST_ADD_SCAN: begin
        if (!valid_q[ptr_q]) begin
          pid_we           = 1'b1;
          rt_we            = 1'b1;
          next_we          = 1'b1;
          valid_d[ptr_q]   = 1'b1;
          doomed_d[ptr_q]  = 1'b0;
          count_d          = count_q + CW'(1);
          state_d          = ST_ADD_LINK;
        end else if (ptr_q == SW'(MAX_PROCESSES - 1)) begin
          status_d = rrss_pkg::StatFull;
          state_d  = ST_OUT;
        end else begin
          ptr_d = ptr_q + SW'(1);
        end
      end

      // link the new slot behind the tail
      ST_ADD_LINK: begin
        if (tail_q == '0) begin
          next0_d = ptr_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = tail_q;
          next_wdata = ptr_q;
        end
        tail_d  = ptr_q;
        state_d = ST_OUT;
      end

      ST_WALK_RD: state_d = ST_WALK_CMP;

      // compare one ring slot, then follow its link
      ST_WALK_CMP: begin
        if (pid_rd == pid_q) begin
          state_d = ST_OUT;
          if (op_q == rrss_pkg::OpFind) begin
            status_d = rrss_pkg::StatOk;
            rt_out_d = rt_rd;
          end else if (ptr_q == cur_q) begin
            status_d = rrss_pkg::StatCurrent;
          end else begin
            status_d = rrss_pkg::StatOk;
            if (prev_q == '0) begin
              next0_d = next_rd;
            end else begin
              next_we    = 1'b1;
              next_waddr = prev_q;
              next_wdata = next_rd;
            end
            if (tail_q == ptr_q) begin
              tail_d = prev_q;
            end
            valid_d[ptr_q]  = 1'b0;
            doomed_d[ptr_q] = 1'b0;
            count_d         = count_q - CW'(1);
          end
        end else begin
          prev_d  = ptr_q;
          ptr_d   = next_rd;
          state_d = (next_rd == '0) ? ST_OUT : ST_WALK_RD;
        end
      end

      // fetch the pid of the slot switched in
      ST_NEW_RD: state_d = ST_NEW_PID;

      ST_NEW_PID: begin
        new_pid_d = sel_pid;
        state_d   = ST_OUT;
      end

      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cur_q    <= '0;
      tail_q   <= '0;
      next0_q  <= '0;
      ticks_q  <= '0;
      count_q  <= CW'(1);
      rt0_q    <= '0;
      valid_q  <= MAX_PROCESSES'(1);
      doomed_q <= '0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      tail_q   <= tail_d;
      next0_q  <= next0_d;
      ticks_q  <= ticks_d;
      count_q  <= count_d;
      rt0_q    <= rt0_d;
      valid_q  <= valid_d;
      doomed_q <= doomed_d;
    end
  end

  // operands and result payload
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pid_q      <= pid_d;
    ptr_q      <= ptr_d;
    prev_q     <= prev_d;
    status_q   <= status_d;
    switched_q <= switched_d;
    old_pid_q  <= old_pid_d;
    new_pid_q  <= new_pid_d;
    rt_out_q   <= rt_out_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign status_o        = status_q;
  assign switched_o      = switched_q;
  assign old_pid_o       = old_pid_q;
  assign new_pid_o       = new_pid_q;
  assign process_count_o = 5'(count_q);
  assign run_time_o      = rt_out_q;

  // the root never leaves the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_q[0])
    else $error("root slot lost");

  // the current slot is always a live slot
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_q[cur_q])
    else $error("current slot not in ring");

  // slot count matches the live slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (32'(count_q) == 32'($countones(valid_q))))
    else $error("slot count out of step");

  // a result beat is only shown while new beats are held off
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input open during result");

endmodule

### tb/sched_checker.sv
// ----------------------------------------------------------------------------
// sched_checker
// Watches the operation, result and register ports of the round-robin slice
// scheduler, predicts each result beat from its own copy of the ring and
// compares every accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module sched_checker
  import rrss_pkg::*;
#(
  parameter int unsigned SLOTS = MaxProcessesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  logic [2:0]       op_i,
  input  logic [15:0]      pid_i,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [1:0]       status_o,
  input  logic             switched_o,
  input  logic [15:0]      old_pid_o,
  input  logic [15:0]      new_pid_o,
  input  logic [4:0]       process_count_o,
  input  logic [31:0]      run_time_o,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic        switched;
    logic [15:0] old_pid;
    logic [15:0] new_pid;
    logic [4:0]  count;
    logic [31:0] run_time;
  } sched_res_t;

  // predicted copy of the scheduler
  logic [15:0] slice_len, root_pid;
  logic        used   [SLOTS];
  logic [15:0] pid_mem[SLOTS];
  logic [3:0]  nxt    [SLOTS];
  logic        doomed [SLOTS];
  logic [31:0] ran    [SLOTS];
  logic [3:0]  cur, tail;
  logic [15:0] ticks_left;
  logic [4:0]  ring_size;

  sched_res_t results_due[$];

  function automatic logic [15:0] pid_at(logic [3:0] s);
    return (s == 0) ? root_pid : pid_mem[s];
  endfunction

  function automatic void switch_next();
    logic [3:0] nx;
    nx = nxt[cur];
    cur = doomed[nx] ? 4'd0 : nx;
    ticks_left = slice_len;
  endfunction

  // one operation applied to the ring, returning its result beat
  function automatic sched_res_t schedule_op(logic [2:0] op, logic [15:0] pid);
    sched_res_t r;
    logic [3:0] s, prev;
    logic       done;
    r = '0;
    r.old_pid = pid_at(cur);
    done = 1'b0;
    s = '0;
    prev = '0;
    case (op)
      OpTick: begin
        if (ticks_left == 0) begin
          switch_next();
          r.switched = 1'b1;
        end else begin
          if (ran[cur] != 32'hFFFF_FFFF) ran[cur] = ran[cur] + 32'd1;
          ticks_left = ticks_left - 16'd1;
        end
      end
      OpAdd: begin
        // lowest free slot, linked just before the root
        for (int i = 1; i < SLOTS; i++)
          if (!done && !used[i]) begin
            s = i[3:0];
            done = 1'b1;
          end
        if (!done) begin
          r.status = StatFull;
        end else begin
          used[s] = 1'b1;
          pid_mem[s] = pid;
          doomed[s] = 1'b0;
          ran[s] = '0;
          nxt[s] = '0;
          nxt[tail] = s;
          tail = s;
          ring_size = ring_size + 5'd1;
        end
      end
      OpRemove: begin
        // first non-root match in ring order
        r.status = StatNotFound;
        for (int i = 0; i < SLOTS; i++)
          if (!done) begin
            s = nxt[prev];
            if (s == 0) begin
              done = 1'b1;
            end else if (pid_mem[s] == pid) begin
              done = 1'b1;
              if (s == cur) begin
                r.status = StatCurrent;
              end else begin
                r.status = StatOk;
                nxt[prev] = nxt[s];
                if (tail == s) tail = prev;
                used[s] = 1'b0;
                doomed[s] = 1'b0;
                ring_size = ring_size - 5'd1;
              end
            end else begin
              prev = s;
            end
          end
      end
      OpYield: begin
        switch_next();
        r.switched = 1'b1;
      end
      OpKill: begin
        doomed[cur] = 1'b1;
        switch_next();
        r.switched = 1'b1;
      end
      OpFind: begin
        // root included, matched against the kernel pid
        r.status = StatNotFound;
        for (int i = 0; i < SLOTS; i++)
          if (!done) begin
            if (pid_at(s) == pid) begin
              r.status = StatOk;
              r.run_time = ran[s];
              done = 1'b1;
            end else begin
              s = nxt[s];
              if (s == 0) done = 1'b1;
            end
          end
      end
      default: ;
    endcase
    r.new_pid = pid_at(cur);
    r.count = ring_size;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             checked_o, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = results_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t e;
    if (!rst_ni) begin
      slice_len = TimeSliceRst;
      root_pid = KernelPidRst;
      for (int i = 0; i < SLOTS; i++) begin
        used[i] = (i == 0);
        pid_mem[i] = '0;
        nxt[i] = '0;
        doomed[i] = 1'b0;
        ran[i] = '0;
      end
      cur = '0;
      tail = '0;
      ticks_left = '0;
      ring_size = 5'd1;
      results_due.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegTimeSlice) slice_len = pwdata[15:0];
        else root_pid = pwdata[15:0];
      end
      // operation beat
      if (in_valid_i && !in_stall_o) results_due.push_back(schedule_op(op_i, pid_i));
      // result beat
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("result beat with nothing expected");
          fail_count_o++;
        end else begin
          e = results_due.pop_front();
          if (status_o != e.status) report("status", status_o, e.status);
          if (switched_o != e.switched) report("switched", switched_o, e.switched);
          if (old_pid_o != e.old_pid) report("old_pid", old_pid_o, e.old_pid);
          if (new_pid_o != e.new_pid) report("new_pid", new_pid_o, e.new_pid);
          if (process_count_o != e.count)
            report("process_count", process_count_o, e.count);
          if (run_time_o != e.run_time) report("run_time", run_time_o, e.run_time);
        end
        checked_o++;
      end
    end
  end

endmodule

### tb/round_robin_slice_scheduler_tb.sv
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler_tb
// Drives operation beats and register writes into the slice scheduler with
// random gaps and result stalls; a checker beside the block predicts and
// compares every result. Directed ring corner cases come first, then random
// phases under several slice lengths and kernel pids.
// ----------------------------------------------------------------------------
module round_robin_slice_scheduler_tb;
  import rrss_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0, in_stall_o;
  logic [2:0]       op_i = '0;
  logic [15:0]      pid_i = '0;
  logic             out_valid_o, out_stall_i = 1'b0;
  logic [1:0]       status_o;
  logic             switched_o;
  logic [15:0]      old_pid_o, new_pid_o;
  logic [4:0]       process_count_o;
  logic [31:0]      run_time_o;
  int               fail_count, pending, checked;

  bit               calm;        // no idling on either side
  logic [15:0]      known_pids[$];
  logic [15:0]      root_pid;

  round_robin_slice_scheduler DUT (.*);

  sched_checker CHK (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .op_i, .pid_i, .out_valid_o, .out_stall_i,
    .status_o, .switched_o, .old_pid_o, .new_pid_o, .process_count_o,
    .run_time_o, .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("** round_robin_slice_scheduler: FAILED **");
    $finish;
  end

  // result side stalls
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 6);
      @(posedge clk_i);
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(negedge clk_i); while (!out_valid_o);
    end
  end

  // one operation beat, entered right after a rising edge
  task automatic send_op(logic [2:0] op, logic [15:0] pid);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    pid_i <= pid;
    if (op == OpAdd) known_pids.push_back(pid);
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  // wait out all results, then write a register
  task automatic write_reg(logic idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom()), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == RegKernelPid) root_pid = val;
  endtask

  function automatic logic [15:0] pick_pid();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65 && known_pids.size() > 0)
      return known_pids[$urandom_range(0, known_pids.size() - 1)];
    if (r < 75) return root_pid;
    return 16'($urandom());
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OpTick;
    if (r < 52) return OpAdd;
    if (r < 68) return OpRemove;
    if (r < 78) return OpYield;
    if (r < 83) return OpKill;
    if (r < 97) return OpFind;
    return 3'($urandom_range(6, 7));
  endfunction

  initial begin
    logic [15:0] slices[6];
    logic [15:0] roots[6];
    root_pid = KernelPidRst;
    slices = '{16'd10, 16'd0, 16'd65535, 16'd1, 16'd3, 16'd2};
    roots = '{16'd0, 16'hFFFF, 16'h1234, 16'hAAAA, 16'h5555, 16'h0000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, full ring, kills and removes
    send_op(OpTick, 16'h0);
    send_op(OpTick, 16'hFFFF);
    send_op(OpFind, 16'h0000);
    send_op(OpFind, 16'hFFFF);
    send_op(OpRemove, 16'h0000);
    send_op(OpAdd, 16'hFFFF);
    send_op(OpAdd, 16'h0000);
    for (int i = 0; i < 13; i++) send_op(OpAdd, (i % 2) ? 16'hAAAA : 16'h5555);
    send_op(OpAdd, 16'h7777);
    send_op(OpYield, 16'h0);
    send_op(OpRemove, 16'hFFFF);
    send_op(OpKill, 16'h0);
    send_op(OpFind, 16'h5555);
    send_op(OpRemove, 16'h5555);
    send_op(OpKill, 16'h0);
    send_op(OpYield, 16'h0);
    send_op(3'd6, 16'h1);
    send_op(3'd7, 16'h2);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegTimeSlice, slices[ph]);
      write_reg(RegKernelPid, roots[ph]);
      calm = (ph == 2);
      for (int n = 0; n < 270; n++) begin
        if (n % 90 == 0 && ph != 2) calm = ~calm;
        send_op(pick_op(), pick_pid());
      end
    end
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (60) @(posedge clk_i);

    $display("ran %0d result beats over 6 register settings, with full ring,", checked);
    $display("kill, remove and find corners and random gaps on both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("** round_robin_slice_scheduler: PASSED **");
    end else begin
      $display("** round_robin_slice_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
